FILE: src/szht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szht_pkg
// Shared types and constants for the screen zone hit table unit.
// ----------------------------------------------------------------------------
package szht_pkg;

  // default sizes, overridden through the top level parameters
  localparam int unsigned MAX_ZONES_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ZNUM_W   = 7;
  localparam int unsigned SCREEN_W = 3;

  // highest zone number the 7-bit fields can name
  localparam int unsigned ZONE_LIMIT = (2 ** ZNUM_W) - 1;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // operation codes on the func field
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_SET,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // control part of one queued transaction
  typedef struct packed {
    op_e                 op;
    logic                range_err;
    logic [ZNUM_W-1:0]   idx;
    logic [ZNUM_W-1:0]   count;
    logic [SCREEN_W-1:0] screen;
  } ctrl_t;

  localparam int unsigned CTRL_W = $bits(ctrl_t);

endpackage

FILE: src/szht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szht_front
// Holds the zone count register and classifies incoming transactions:
// decodes the operation, clamps the count and checks the zone number.
// ----------------------------------------------------------------------------
module szht_front
  import szht_pkg::*;
#(
  parameter int unsigned MAX_ZONES  = MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ZNUM_W-1:0]            cfg_wdata_i,
  input  logic [FUNC_W-1:0]            func_i,
  input  logic [ZNUM_W-1:0]            zone_number_i,
  input  logic [SCREEN_W-1:0]          screen_i,
  input  logic signed [COORD_BITS-1:0] left_i,
  input  logic signed [COORD_BITS-1:0] top_i,
  input  logic signed [COORD_BITS-1:0] right_i,
  input  logic signed [COORD_BITS-1:0] bottom_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic [CTRL_W+4*COORD_BITS-1:0] item_o
);

  localparam int unsigned TBL_DEPTH = (MAX_ZONES < ZONE_LIMIT) ? MAX_ZONES : ZONE_LIMIT;
  localparam logic [ZNUM_W-1:0] TBL_DEPTH_Z = ZNUM_W'(TBL_DEPTH);

  logic [ZNUM_W-1:0]       zin_q;
  logic [ZNUM_W-1:0]       count;
  ctrl_t                   ctrl;
  logic [4*COORD_BITS-1:0] data;

  // zone count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zin_q <= '0;
    end else if (cfg_we_i) begin
      zin_q <= cfg_wdata_i;
    end
  end

  // count clamped to the table size
  assign count = (zin_q > TBL_DEPTH_Z) ? TBL_DEPTH_Z : zin_q;

  // classify the transaction
  always_comb begin
    ctrl.range_err = (zone_number_i == '0) || (zone_number_i > count);
    ctrl.idx       = zone_number_i - ZNUM_W'(1);
    ctrl.count     = count;
    ctrl.screen    = screen_i;
    data           = {left_i, top_i, right_i, bottom_i};
    unique case (func_i)
      FUNC_QUERY: begin
        ctrl.op = OP_QUERY;
        data    = {point_x_i, point_y_i, {(2*COORD_BITS){1'b0}}};
      end
      FUNC_SET:   ctrl.op = OP_SET;
      FUNC_RESET: ctrl.op = OP_CLEAR;
      default:    ctrl.op = OP_NOP;
    endcase
  end

  assign item_o = {ctrl, data};

endmodule

FILE: src/szht_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szht_queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module szht_queue
  import szht_pkg::*;
#(
  parameter int unsigned WIDTH = CTRL_W,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != DEPTH_C);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/szht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szht_back
// Zone table and executor: writes or clears zones, scans the table one
// entry per cycle for a query and holds the result until it is taken.
// ----------------------------------------------------------------------------
module szht_back
  import szht_pkg::*;
#(
  parameter int unsigned MAX_ZONES  = MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  logic [CTRL_W+4*COORD_BITS-1:0] q_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ZNUM_W-1:0]              hit_zone_o,
  output logic                           status_o
);

  localparam int unsigned TBL_DEPTH = (MAX_ZONES < ZONE_LIMIT) ? MAX_ZONES : ZONE_LIMIT;
  localparam int unsigned IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int unsigned DATA_W    = 4 * COORD_BITS;
  localparam int unsigned ENT_W     = SCREEN_W + DATA_W;
  localparam int unsigned L_MSB     = DATA_W - 1;
  localparam int unsigned T_MSB     = DATA_W - 1 - COORD_BITS;
  localparam int unsigned R_MSB     = DATA_W - 1 - 2 * COORD_BITS;
  localparam int unsigned B_MSB     = DATA_W - 1 - 3 * COORD_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  state_e                  state_q;
  ctrl_t                   hd;
  logic [DATA_W-1:0]       hd_data;
  logic                    pop;

  logic [ENT_W-1:0]        zone_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]    vld_q;
  logic [ENT_W-1:0]        rdata_q;
  logic                    rd_vld_q;
  logic                    we, re;
  logic [IDX_W-1:0]        wa, ra;
  logic [ENT_W-1:0]        wd;

  logic [IDX_W-1:0]        cur_q;
  logic [ZNUM_W-1:0]       count_q;
  logic [SCREEN_W-1:0]     scr_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [ZNUM_W-1:0]       hit_q;
  logic                    status_q;

  logic [SCREEN_W-1:0]     e_tag;
  logic signed [COORD_BITS-1:0] e_l, e_t, e_r, e_b;
  logic                    match, last;
  logic [ZNUM_W-1:0]       cur_num;

  // queue head
  assign hd      = ctrl_t'(q_data_i[CTRL_W+DATA_W-1 -: CTRL_W]);
  assign hd_data = q_data_i[DATA_W-1:0];
  assign pop       = (state_q == S_IDLE) && q_valid_i;
  assign q_ready_o = (state_q == S_IDLE);

  // fields of the entry under test
  assign e_tag = rdata_q[ENT_W-1 -: SCREEN_W];
  assign e_l   = rdata_q[L_MSB -: COORD_BITS];
  assign e_t   = rdata_q[T_MSB -: COORD_BITS];
  assign e_r   = rdata_q[R_MSB -: COORD_BITS];
  assign e_b   = rdata_q[B_MSB -: COORD_BITS];

  // strict containment on the query screen
  assign match = rd_vld_q && (e_tag == scr_q) && (px_q > e_l) && (py_q > e_t) &&
                 (px_q < e_r) && (py_q < e_b);
  assign cur_num = ZNUM_W'(cur_q) + ZNUM_W'(1);
  assign last    = (cur_num == count_q);

  // table port control
  always_comb begin
    we = pop && ((hd.op == OP_SET) || (hd.op == OP_CLEAR)) && !hd.range_err;
    wa = hd.idx[IDX_W-1:0];
    wd = (hd.op == OP_SET) ? {hd.screen, hd_data} : '0;
    re = 1'b0;
    ra = '0;
    if (pop && (hd.op == OP_QUERY) && (hd.count != '0)) begin
      re = 1'b1;
    end else if ((state_q == S_SCAN) && !match && !last) begin
      re = 1'b1;
      ra = cur_q + IDX_W'(1);
    end
  end

  // zone memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      zone_mem[wa] <= wd;
    end
    if (re) begin
      rdata_q  <= zone_mem[ra];
      rd_vld_q <= vld_q[ra];
    end
  end

  // written flags, cleared at reset so unwritten entries never match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wa] <= 1'b1;
    end
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= '0;
      count_q  <= '0;
      scr_q    <= '0;
      px_q     <= '0;
      py_q     <= '0;
      hit_q    <= '0;
      status_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            hit_q <= '0;
            unique case (hd.op)
              OP_QUERY: begin
                scr_q    <= hd.screen;
                px_q     <= hd_data[L_MSB -: COORD_BITS];
                py_q     <= hd_data[T_MSB -: COORD_BITS];
                count_q  <= hd.count;
                cur_q    <= '0;
                status_q <= 1'b0;
                state_q  <= (hd.count != '0) ? S_SCAN : S_OUT;
              end
              OP_SET, OP_CLEAR: begin
                status_q <= hd.range_err;
                state_q  <= S_OUT;
              end
              OP_NOP: begin
                status_q <= 1'b0;
                state_q  <= S_OUT;
              end
              default: begin
                status_q <= 1'b0;
                state_q  <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_q   <= cur_num;
            state_q <= S_OUT;
          end else if (last) begin
            state_q <= S_OUT;
          end else begin
            cur_q <= cur_q + IDX_W'(1);
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign hit_zone_o  = hit_q;
  assign status_o    = status_q;

endmodule

FILE: src/screen_zone_hit_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_zone_hit_table_unit
// Table of screen-tagged rectangular zones with set, clear and point query.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o    | func, zone_number, screen, corners, point
//  out     | out_valid_o / out_ready_i  | hit_zone, status
//  cfg     | cfg_we_i                   | cfg_wdata_i (zones in use)
//
// A set, clear or unknown operation passes through the queue and then the
// executor, which registers its result. A query scans the zones up to and
// including the first hit, or up to the clamped count when none hits: the
// single read port of the zone memory delivers one entry per cycle. After
// reset the table reads as empty at once. A two-entry queue keeps taking
// transactions, until it is full, while a result waits on out_ready_i.
// ----------------------------------------------------------------------------
module screen_zone_hit_table_unit
  import szht_pkg::*;
#(
  parameter int unsigned MAX_ZONES  = MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ZNUM_W-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [FUNC_W-1:0]            func_i,
  input  logic [ZNUM_W-1:0]            zone_number_i,
  input  logic [SCREEN_W-1:0]          screen_i,
  input  logic signed [COORD_BITS-1:0] left_i,
  input  logic signed [COORD_BITS-1:0] top_i,
  input  logic signed [COORD_BITS-1:0] right_i,
  input  logic signed [COORD_BITS-1:0] bottom_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ZNUM_W-1:0]            hit_zone_o,
  output logic                         status_o
);

  localparam int unsigned ITEM_W = CTRL_W + 4 * COORD_BITS;

  logic [ITEM_W-1:0] item;
  logic [ITEM_W-1:0] q_data;
  logic              q_valid, q_ready;

  // classification front
  szht_front #(
    .MAX_ZONES  (MAX_ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .zone_number_i (zone_number_i),
    .screen_i      (screen_i),
    .left_i        (left_i),
    .top_i         (top_i),
    .right_i       (right_i),
    .bottom_i      (bottom_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .item_o        (item)
  );

  // decoupling queue
  szht_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // table and executor
  szht_back #(
    .MAX_ZONES  (MAX_ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_zone_o  (hit_zone_o),
    .status_o    (status_o)
  );

endmodule
